/* hw/rtl/lsbm_pkg.sv */
`default_nettype none
package lsbm_pkg;

    // field widths
    localparam int SAMPLE_W = 10;
    localparam int AVG_W    = 10;
    localparam int BRIGHT_W = 8;
    localparam int OFFSET_W = 8;
    localparam int GAIN_W   = 4;
    localparam int GSQ_W    = 2 * GAIN_W;

    // radicand is gain squared times average, root is half as wide
    localparam int RAD_W  = GSQ_W + AVG_W;
    localparam int ROOT_W = (RAD_W + 1) / 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = CFG_IDX_W'(1);

    localparam logic [OFFSET_W-1:0] OFFSET_RST = OFFSET_W'(4);
    localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(7);
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = BRIGHT_W'(255);

    // default build settings
    localparam int WINDOW_DEF      = 6;
    localparam int QUEUE_DEPTH_DEF = 2;

    // one queue beat in either direction
    typedef struct packed {
        logic             valid;
        logic [AVG_W-1:0] avg;
    } t_q_beat;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_MUL,
        BS_ROOT,
        BS_DONE
    } t_back_state;

endpackage
`default_nettype wire

/* hw/rtl/lsbm_front.sv */
`default_nettype none
module lsbm_front #(
    parameter int WINDOW = lsbm_pkg::WINDOW_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [lsbm_pkg::SAMPLE_W-1:0] i_light_sample,
    input  wire logic                          i_q_full,
    output lsbm_pkg::t_q_beat                  o_push
);

    localparam int SUM_W  = $clog2(WINDOW * ((1 << lsbm_pkg::SAMPLE_W) - 1) + 1);
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    // reciprocal rounded up, exact floor quotient for every sum
    localparam int RCP_SH = SUM_W + $clog2(WINDOW);
    localparam int RCP    = ((1 << RCP_SH) + WINDOW - 1) / WINDOW;
    localparam int RCP_W  = $clog2(RCP + 1);
    localparam int PROD_W = SUM_W + RCP_W;

    lsbm_pkg::t_front_state r_state, n_state;

    logic [lsbm_pkg::SAMPLE_W-1:0] r_ring [WINDOW];
    logic [POS_W-1:0]              r_pos, n_pos;
    logic [SUM_W-1:0]              r_sum, n_sum;
    logic [PROD_W-1:0]             r_prod, n_prod;
    logic                          accept;

    assign accept = i_valid && o_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsbm_pkg::FS_IDLE: begin
                if (i_valid) begin
                    n_state = lsbm_pkg::FS_DIV;
                end
            end
            lsbm_pkg::FS_DIV: begin
                n_state = lsbm_pkg::FS_PUSH;
            end
            lsbm_pkg::FS_PUSH: begin
                if (!i_q_full) begin
                    n_state = lsbm_pkg::FS_IDLE;
                end
            end
            default: begin
                n_state = lsbm_pkg::FS_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ready      = 1'b0;
        o_push.valid = 1'b0;
        o_push.avg   = r_prod[RCP_SH +: lsbm_pkg::AVG_W];
        case (r_state)
            lsbm_pkg::FS_IDLE: begin
                o_ready = 1'b1;
            end
            lsbm_pkg::FS_PUSH: begin
                o_push.valid = !i_q_full;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // ring position, running sum and quotient product
    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_prod = r_prod;
        if (accept) begin
            n_sum = r_sum - SUM_W'(r_ring[r_pos]) + SUM_W'(i_light_sample);
            if (r_pos == POS_W'(WINDOW - 1)) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
        if (r_state == lsbm_pkg::FS_DIV) begin
            n_prod = PROD_W'(r_sum) * PROD_W'(RCP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsbm_pkg::FS_IDLE;
            r_pos   <= '0;
            r_sum   <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            if (accept) begin
                r_ring[r_pos] <= i_light_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

endmodule
`default_nettype wire

/* hw/rtl/lsbm_queue.sv */
`default_nettype none
module lsbm_queue #(
    parameter int DEPTH = lsbm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lsbm_pkg::t_q_beat i_push,
    output logic                   o_full,
    output lsbm_pkg::t_q_beat      o_head,
    input  wire logic              i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [lsbm_pkg::AVG_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]           r_wr, n_wr;
    logic [PTR_W-1:0]           r_rd, n_rd;
    logic [CNT_W-1:0]           r_cnt, n_cnt;

    assign o_full       = (r_cnt == CNT_W'(DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.avg   = r_mem[r_rd];

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push.valid) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push.valid && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push.valid) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.avg;
        end
    end

    // no write into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> (r_cnt != CNT_W'(DEPTH)))
        else $error("queue written while full");

    // no read from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("queue read while empty");

    // a lone write adds one entry
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.valid && !i_pop) |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("queue count did not follow a write");

endmodule
`default_nettype wire

/* hw/rtl/lsbm_back.sv */
`default_nettype none
module lsbm_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lsbm_pkg::t_q_beat             i_head,
    output logic                               o_pop,
    input  wire logic [lsbm_pkg::OFFSET_W-1:0] i_offset,
    input  wire logic [lsbm_pkg::GAIN_W-1:0]   i_gain,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [lsbm_pkg::BRIGHT_W-1:0]      o_brightness
);

    localparam int RAD_W  = lsbm_pkg::RAD_W;
    localparam int ROOT_W = lsbm_pkg::ROOT_W;
    localparam int GSQ_W  = lsbm_pkg::GSQ_W;
    localparam int SAT_W  = ROOT_W + 1;

    lsbm_pkg::t_back_state r_state, n_state;

    logic [lsbm_pkg::AVG_W-1:0] r_avg, n_avg;
    logic [GSQ_W-1:0]           r_gsq, n_gsq;
    logic [RAD_W-1:0]           r_rem, n_rem;
    logic [RAD_W-1:0]           r_root, n_root;
    logic [RAD_W-1:0]           r_bit, n_bit;
    logic                       r_out_valid, n_out_valid;
    logic [lsbm_pkg::BRIGHT_W-1:0] r_brightness, n_brightness;

    logic                       out_free;
    logic                       load_out;
    logic [RAD_W:0]             trial;
    logic [SAT_W-1:0]           bright_sum;

    assign out_free = !r_out_valid || i_ready;
    assign trial    = {1'b0, r_root} + {1'b0, r_bit};
    assign bright_sum = SAT_W'(i_offset) + SAT_W'(r_root[ROOT_W-1:0]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsbm_pkg::BS_IDLE: begin
                if (i_head.valid) begin
                    n_state = lsbm_pkg::BS_MUL;
                end
            end
            lsbm_pkg::BS_MUL: begin
                n_state = lsbm_pkg::BS_ROOT;
            end
            lsbm_pkg::BS_ROOT: begin
                if (r_bit[0]) begin
                    n_state = lsbm_pkg::BS_DONE;
                end
            end
            lsbm_pkg::BS_DONE: begin
                if (out_free) begin
                    n_state = lsbm_pkg::BS_IDLE;
                end
            end
            default: begin
                n_state = lsbm_pkg::BS_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            lsbm_pkg::BS_IDLE: begin
                o_pop = i_head.valid;
            end
            lsbm_pkg::BS_DONE: begin
                load_out = out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // operand capture, product and one root digit a cycle
    always_comb begin
        n_avg  = r_avg;
        n_gsq  = r_gsq;
        n_rem  = r_rem;
        n_root = r_root;
        n_bit  = r_bit;
        case (r_state)
            lsbm_pkg::BS_IDLE: begin
                n_avg = i_head.avg;
                n_gsq = GSQ_W'(i_gain) * GSQ_W'(i_gain);
            end
            lsbm_pkg::BS_MUL: begin
                n_rem  = RAD_W'(r_gsq) * RAD_W'(r_avg);
                n_root = '0;
                n_bit  = RAD_W'(1) << (RAD_W - 2);
            end
            lsbm_pkg::BS_ROOT: begin
                if ({1'b0, r_rem} >= trial) begin
                    n_rem  = r_rem - trial[RAD_W-1:0];
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
            end
            default: begin
                n_bit = r_bit;
            end
        endcase
    end

    // output register, saturated offset plus root
    always_comb begin
        n_out_valid  = r_out_valid;
        n_brightness = r_brightness;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
            if (bright_sum > SAT_W'(lsbm_pkg::BRIGHT_MAX)) begin
                n_brightness = lsbm_pkg::BRIGHT_MAX;
            end else begin
                n_brightness = bright_sum[lsbm_pkg::BRIGHT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsbm_pkg::BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_avg        <= n_avg;
        r_gsq        <= n_gsq;
        r_rem        <= n_rem;
        r_root       <= n_root;
        r_bit        <= n_bit;
        r_brightness <= n_brightness;
    end

    assign o_valid      = r_out_valid;
    assign o_brightness = r_brightness;

    // a new beat only comes from the finishing state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_out_valid && $past(r_state == lsbm_pkg::BS_DONE)))
        else $error("output loaded outside the finishing state");

endmodule
`default_nettype wire

/* hw/rtl/light_sensor_brightness_mapper.sv */
// light sensor brightness mapper
// input channel i_valid / o_ready carries one 10-bit sample a beat; the block
// keeps a moving window of the last WINDOW samples and their sum, takes the
// floor average and returns offset + isqrt(gain^2 * average), saturated at 255,
// one brightness beat on o_valid / i_ready for every sample.
// configuration: i_cfg_valid / o_cfg_ready with i_cfg_index (0 offset, 1 gain)
// and i_cfg_data; o_cfg_ready is always high, other indexes are dropped.
// the front takes a sample in its idle state, updates the ring and sum, then
// passes through the reciprocal multiply state and a push state that holds
// while the queue is full; o_ready is low until it is back in idle.
// the back pops an average, multiplies in its product state and runs a
// radix-4 root, one root bit per step, then loads the output register; it
// pops no new average before that, and the root loop sets the rate.
// when the receiver stalls the result waits in the output register while the
// back finishes the next item and the queue fills; then the front holds in
// its push state and o_ready stays low.
// reset (synchronous, active low) clears the ring, sum, position and queue
// and loads offset 4, gain 7.
`default_nettype none
module light_sensor_brightness_mapper #(
    parameter int WINDOW      = lsbm_pkg::WINDOW_DEF,
    parameter int QUEUE_DEPTH = lsbm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [lsbm_pkg::SAMPLE_W-1:0]   i_light_sample,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [lsbm_pkg::BRIGHT_W-1:0]        o_brightness,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [lsbm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lsbm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [lsbm_pkg::OFFSET_W-1:0] r_offset;
    logic [lsbm_pkg::GAIN_W-1:0]   r_gain;

    lsbm_pkg::t_q_beat push;
    lsbm_pkg::t_q_beat head;
    logic              q_full;
    logic              pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= lsbm_pkg::OFFSET_RST;
            r_gain   <= lsbm_pkg::GAIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lsbm_pkg::REG_OFFSET: begin
                    r_offset <= i_cfg_data[lsbm_pkg::OFFSET_W-1:0];
                end
                lsbm_pkg::REG_GAIN: begin
                    r_gain <= i_cfg_data[lsbm_pkg::GAIN_W-1:0];
                end
                default: begin
                    r_offset <= r_offset;
                end
            endcase
        end
    end

    lsbm_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_light_sample (i_light_sample),
        .i_q_full       (q_full),
        .o_push         (push)
    );

    lsbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    lsbm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .i_offset     (r_offset),
        .i_gain       (r_gain),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_brightness (o_brightness)
    );

endmodule
`default_nettype wire
